FILE: rtl/lsmm_pkg.sv
// Shared widths, codes and state type for the latency statistics block.
`timescale 1ns / 1ps
`default_nettype none
package lsmm_pkg;

   localparam int unsigned SAMPLE_W     = 32;
   localparam int unsigned TOTAL_W      = 32;
   localparam int unsigned SUM_W        = 64;
   localparam int unsigned FRAC_W       = 8;
   localparam int unsigned MEAN_W       = 40;
   localparam int unsigned MEDIAN_W     = 33;
   localparam int unsigned STORED_W     = 11;
   localparam int unsigned GROUP_SIZE   = 32;
   localparam int unsigned CAPACITY_DEF = 1024;
   localparam int unsigned COUNT_W_DEF  = $clog2(CAPACITY_DEF + 1);

   // request codes
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LAUNCH,
      ST_CALC
   } lsmm_state_type;

endpackage : lsmm_pkg
`default_nettype wire

FILE: rtl/lsmm_req_if.sv
// Request channel: operation code and latency sample.
`timescale 1ns / 1ps
`default_nettype none
interface lsmm_req_if;
   import lsmm_pkg::*;

   logic                valid;
   logic                ready;
   logic                req_type;
   logic [SAMPLE_W-1:0] sample_us;

   modport source (output valid, output req_type, output sample_us, input ready);
   modport sink   (input valid, input req_type, input sample_us, output ready);

endinterface : lsmm_req_if
`default_nettype wire

FILE: rtl/lsmm_rsp_if.sv
// Response channel: statistics snapshot after each request.
`timescale 1ns / 1ps
`default_nettype none
interface lsmm_rsp_if;
   import lsmm_pkg::*;

   logic                valid;
   logic                ready;
   logic [TOTAL_W-1:0]  sample_total;
   logic [SAMPLE_W-1:0] min_us;
   logic [SAMPLE_W-1:0] max_us;
   logic [MEAN_W-1:0]   mean_q8;
   logic [MEDIAN_W-1:0] median_half_us;
   logic [STORED_W-1:0] stored_total;
   logic                store_full;

   modport source (output valid, output sample_total, output min_us, output max_us,
                   output mean_q8, output median_half_us, output stored_total,
                   output store_full, input ready);
   modport sink   (input valid, input sample_total, input min_us, input max_us,
                   input mean_q8, input median_half_us, input stored_total,
                   input store_full, output ready);

endinterface : lsmm_rsp_if
`default_nettype wire

FILE: rtl/latency_stats_min_max_mean_median_core.sv
// Latency statistics core: count, min, max, Q8 mean and median over a sorted cell row.
// An accepted request is registered, applied in the update state and starts the bit-serial mean
// divider in the launch state; the calc state waits until the divider is done and the median
// selection has drained through the row of group registers.
// One request is in flight at a time; a new one is taken only in the idle state.
// Reset (synchronous, active high) zeroes all statistics; the sample row needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module latency_stats_min_max_mean_median_core #(
   parameter int unsigned CAPACITY = lsmm_pkg::CAPACITY_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lsmm_req_if.sink  req_chan,
   lsmm_rsp_if.source rsp_chan
);
   import lsmm_pkg::*;

   localparam int unsigned COUNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int unsigned PADDED  = GROUPS * GROUP_SIZE;
   localparam int unsigned DRAIN_W = $clog2(GROUPS + 1);

   // ---------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------
   lsmm_state_type state_ff, state_in;

   logic                req_type_ff;
   logic [SAMPLE_W-1:0] sample_ff;

   logic [TOTAL_W-1:0]  sample_count_ff;
   logic [SUM_W-1:0]    sample_sum_ff;
   logic [SAMPLE_W-1:0] min_ff;
   logic [SAMPLE_W-1:0] max_ff;
   logic [COUNT_W-1:0]  stored_count_ff;
   logic [DRAIN_W-1:0]  drain_cnt_ff;

   logic                store_full;
   logic                insert_en;
   logic                div_start;
   logic                div_busy;
   logic [MEAN_W-1:0]   quotient;
   logic                drain_done;
   logic                work_done;
   logic                rsp_load;
   logic                req_ready;
   logic [COUNT_W-1:0]  hi_idx;
   logic [COUNT_W-1:0]  lo_idx;

   // response holding register
   logic                rsp_valid_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;
   logic [SAMPLE_W-1:0] rsp_min_ff;
   logic [SAMPLE_W-1:0] rsp_max_ff;
   logic [MEAN_W-1:0]   rsp_mean_ff;
   logic [MEDIAN_W-1:0] rsp_median_ff;
   logic [STORED_W-1:0] rsp_stored_ff;
   logic                rsp_full_ff;

   // ---------------------------------------------------------------
   // Cell row and median drain chain
   // ---------------------------------------------------------------
   logic [SAMPLE_W-1:0] cell_value   [CAPACITY];
   logic                cell_greater [CAPACITY];
   logic [SAMPLE_W-1:0] pick_lo      [PADDED];
   logic [SAMPLE_W-1:0] pick_hi      [PADDED];
   logic [SAMPLE_W-1:0] grp_lo       [GROUPS];
   logic [SAMPLE_W-1:0] grp_hi       [GROUPS];
   logic [SAMPLE_W-1:0] acc_lo_ff    [GROUPS];
   logic [SAMPLE_W-1:0] acc_hi_ff    [GROUPS];

   assign store_full = stored_count_ff >= COUNT_W'(CAPACITY);

   // median positions: the upper middle is n/2, the lower one sits just below for even n
   always_comb begin
      hi_idx = stored_count_ff >> 1;
      lo_idx = stored_count_ff[0] ? hi_idx : hi_idx - 1'b1;
   end

   for (genvar i = 0; i < PADDED; i++) begin : g_cell
      if (i < CAPACITY) begin : g_live
         logic [SAMPLE_W-1:0] left_value;
         logic                left_greater;

         if (i == 0) begin : g_first
            assign left_value   = '0;
            assign left_greater = 1'b0;
         end else begin : g_rest
            assign left_value   = cell_value[i-1];
            assign left_greater = cell_greater[i-1];
         end

         lsmm_cell #(
            .CNT_W (COUNT_W),
            .INDEX (i)
         ) u_cell (
            .clock        (clock),
            .insert_en    (insert_en),
            .sample       (sample_ff),
            .count        (stored_count_ff),
            .lo_idx       (lo_idx),
            .hi_idx       (hi_idx),
            .left_value   (left_value),
            .left_greater (left_greater),
            .value        (cell_value[i]),
            .greater      (cell_greater[i]),
            .lo_pick      (pick_lo[i]),
            .hi_pick      (pick_hi[i])
         );
      end else begin : g_pad
         // pad the last group so every group has the same width
         assign pick_lo[i] = '0;
         assign pick_hi[i] = '0;
      end
   end

   // OR the one-hot picks of each group of cells
   for (genvar g = 0; g < GROUPS; g++) begin : g_grp
      logic [SAMPLE_W-1:0] lo_or;
      logic [SAMPLE_W-1:0] hi_or;

      always_comb begin
         lo_or = '0;
         hi_or = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            lo_or = lo_or | pick_lo[g*GROUP_SIZE + k];
            hi_or = hi_or | pick_hi[g*GROUP_SIZE + k];
         end
      end

      assign grp_lo[g] = lo_or;
      assign grp_hi[g] = hi_or;
   end

   // advance the picked values one group per cycle towards the end of the row;
   // the last register settles once a change has passed through every register of the chain
   always_ff @(posedge clock) begin
      acc_lo_ff[0] <= grp_lo[0];
      acc_hi_ff[0] <= grp_hi[0];
      for (int g = 1; g < GROUPS; g++) begin
         acc_lo_ff[g] <= acc_lo_ff[g-1] | grp_lo[g];
         acc_hi_ff[g] <= acc_hi_ff[g-1] | grp_hi[g];
      end
   end

   assign drain_done = drain_cnt_ff == DRAIN_W'(GROUPS - 1);

   // ---------------------------------------------------------------
   // Mean divider: sum * 256 / count; the top 32 quotient bits are known zero
   // because the sum never reaches count * 2^32
   // ---------------------------------------------------------------
   lsmm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num_hi   (sample_sum_ff[SUM_W-1:SUM_W-SAMPLE_W]),
      .num_lo   ({sample_sum_ff[SUM_W-SAMPLE_W-1:0], FRAC_W'(0)}),
      .divisor  (sample_count_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign work_done = drain_done && !div_busy;

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (work_done && (!rsp_valid_ff || rsp_chan.ready)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      insert_en = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // take nothing while reset is held
            req_ready = !reset;
         end
         ST_UPDATE: begin
            insert_en = (req_type_ff == REQ_ADD) && !store_full;
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
         end
         ST_CALC: begin
            rsp_load = work_done && (!rsp_valid_ff || rsp_chan.ready);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold the accepted transaction for the update cycle
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_ready) begin
         req_type_ff <= req_chan.req_type;
         sample_ff   <= req_chan.sample_us;
      end
   end

   // ---------------------------------------------------------------
   // Running statistics
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         sample_sum_ff   <= '0;
         min_ff          <= '0;
         max_ff          <= '0;
         stored_count_ff <= '0;
      end else if (state_ff == ST_UPDATE) begin
         if (req_type_ff == REQ_CLEAR) begin
            sample_count_ff <= '0;
            sample_sum_ff   <= '0;
            min_ff          <= '0;
            max_ff          <= '0;
            stored_count_ff <= '0;
         end else begin
            // a full row drops the sample but the scalar statistics still see it
            if (!store_full) begin
               stored_count_ff <= stored_count_ff + 1'b1;
            end
            if ((sample_count_ff == '0) || (sample_ff < min_ff)) begin
               min_ff <= sample_ff;
            end
            if ((sample_count_ff == '0) || (sample_ff > max_ff)) begin
               max_ff <= sample_ff;
            end
            // freeze count and sum once the count saturates
            if (sample_count_ff != '1) begin
               sample_count_ff <= sample_count_ff + 1'b1;
               sample_sum_ff   <= sample_sum_ff + SUM_W'(sample_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_cnt_ff <= '0;
      end else if (state_ff == ST_LAUNCH) begin
         drain_cnt_ff <= '0;
      end else if ((state_ff == ST_CALC) && !drain_done) begin
         drain_cnt_ff <= drain_cnt_ff + 1'b1;
      end
   end

   // ---------------------------------------------------------------
   // Response register: lets the next request in while this one waits
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_total_ff  <= sample_count_ff;
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_mean_ff   <= (sample_count_ff == '0) ? '0 : quotient;
         // an empty row reports zero; odd counts pick the same cell twice
         rsp_median_ff <= (stored_count_ff == '0) ? '0 :
                          ({1'b0, acc_lo_ff[GROUPS-1]} + {1'b0, acc_hi_ff[GROUPS-1]});
         rsp_stored_ff <= STORED_W'(stored_count_ff);
         rsp_full_ff   <= store_full;
      end
   end

   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.sample_total   = rsp_total_ff;
   assign rsp_chan.min_us         = rsp_min_ff;
   assign rsp_chan.max_us         = rsp_max_ff;
   assign rsp_chan.mean_q8        = rsp_mean_ff;
   assign rsp_chan.median_half_us = rsp_median_ff;
   assign rsp_chan.stored_total   = rsp_stored_ff;
   assign rsp_chan.store_full     = rsp_full_ff;

endmodule : latency_stats_min_max_mean_median_core
`default_nettype wire

FILE: rtl/lsmm_cell.sv
// One slot of the sorted sample row: compare, shift right on insert, pick for median.
`timescale 1ns / 1ps
`default_nettype none
module lsmm_cell #(
   parameter int unsigned CNT_W = lsmm_pkg::COUNT_W_DEF,
   parameter int unsigned INDEX = 0
) (
   input  wire logic                          clock,
   input  wire logic                          insert_en,
   input  wire logic [lsmm_pkg::SAMPLE_W-1:0] sample,
   input  wire logic [CNT_W-1:0]              count,
   input  wire logic [CNT_W-1:0]              lo_idx,
   input  wire logic [CNT_W-1:0]              hi_idx,
   input  wire logic [lsmm_pkg::SAMPLE_W-1:0] left_value,
   input  wire logic                          left_greater,
   output logic      [lsmm_pkg::SAMPLE_W-1:0] value,
   output logic                               greater,
   output logic      [lsmm_pkg::SAMPLE_W-1:0] lo_pick,
   output logic      [lsmm_pkg::SAMPLE_W-1:0] hi_pick
);
   import lsmm_pkg::*;

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

   logic [SAMPLE_W-1:0] value_ff;
   logic [SAMPLE_W-1:0] value_in;
   logic                occupied;
   logic                take;

   always_comb begin
      occupied = MY_IDX < count;
      greater  = occupied && (value_ff > sample);
      // an occupied slot moves when it holds a larger value; the first free slot always takes
      take     = occupied ? greater : (MY_IDX == count);
      value_in = left_greater ? left_value : sample;
   end

   always_ff @(posedge clock) begin
      if (insert_en && take) begin
         value_ff <= value_in;
      end
   end

   assign value   = value_ff;
   assign lo_pick = (MY_IDX == lo_idx) ? value_ff : '0;
   assign hi_pick = (MY_IDX == hi_idx) ? value_ff : '0;

endmodule : lsmm_cell
`default_nettype wire

FILE: rtl/lsmm_divider.sv
// Restoring divider, one quotient bit per cycle, for the Q8 mean.
`timescale 1ns / 1ps
`default_nettype none
module lsmm_divider (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lsmm_pkg::SAMPLE_W-1:0] num_hi,
   input  wire logic [lsmm_pkg::MEAN_W-1:0]   num_lo,
   input  wire logic [lsmm_pkg::SAMPLE_W-1:0] divisor,
   output logic                               busy,
   output logic      [lsmm_pkg::MEAN_W-1:0]   quotient
);
   import lsmm_pkg::*;

   localparam int unsigned ITER_W = $clog2(MEAN_W + 1);

   logic [SAMPLE_W-1:0] rem_ff,  rem_in;
   logic [MEAN_W-1:0]   shreg_ff, shreg_in;
   logic [SAMPLE_W-1:0] div_ff;
   logic [ITER_W-1:0]   iter_ff;
   logic                busy_ff;
   logic [SAMPLE_W:0]   trial;
   logic [SAMPLE_W:0]   diff;
   logic                fits;

   // the partial remainder always stays below the divisor, so it fits 32 bits
   always_comb begin
      trial    = {rem_ff, shreg_ff[MEAN_W-1]};
      diff     = trial - {1'b0, div_ff};
      fits     = trial >= {1'b0, div_ff};
      rem_in   = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
      shreg_in = {shreg_ff[MEAN_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= ITER_W'(MEAN_W);
      end else if (busy_ff) begin
         iter_ff <= iter_ff - 1'b1;
         if (iter_ff == ITER_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= num_hi;
         shreg_ff <= num_lo;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         rem_ff   <= rem_in;
         shreg_ff <= shreg_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = shreg_ff;

endmodule : lsmm_divider
`default_nettype wire

FILE: rtl/lsmm_checker.sv
// Port-level checks for the latency statistics core, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module lsmm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lsmm_pkg::TOTAL_W-1:0]  sample_total,
   input wire logic [lsmm_pkg::SAMPLE_W-1:0] min_us,
   input wire logic [lsmm_pkg::SAMPLE_W-1:0] max_us,
   input wire logic [lsmm_pkg::MEAN_W-1:0]   mean_q8,
   input wire logic [lsmm_pkg::MEDIAN_W-1:0] median_half_us,
   input wire logic [lsmm_pkg::STORED_W-1:0] stored_total,
   input wire logic                          store_full
);
   import lsmm_pkg::*;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_total) && $stable(min_us)
         && $stable(max_us) && $stable(mean_q8) && $stable(median_half_us)
         && $stable(stored_total) && $stable(store_full))
      else $error("response changed while stalled");

   // one request in flight: the cycle after acceptance the block is busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // no samples means every statistic reads zero
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (sample_total == '0) |-> (min_us == '0) && (max_us == '0)
         && (mean_q8 == '0) && (median_half_us == '0) && (stored_total == '0)
         && !store_full)
      else $error("non-zero statistics with no samples");

   // min never exceeds max, and mean and median never exceed the largest sample seen
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (sample_total != '0) |-> (min_us <= max_us)
         && (mean_q8 <= {max_us, FRAC_W'(0)}) && (median_half_us <= {max_us, 1'b0}))
      else $error("statistics out of range");

endmodule : lsmm_checker

bind latency_stats_min_max_mean_median_core lsmm_checker u_lsmm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .sample_total   (rsp_chan.sample_total),
   .min_us         (rsp_chan.min_us),
   .max_us         (rsp_chan.max_us),
   .mean_q8        (rsp_chan.mean_q8),
   .median_half_us (rsp_chan.median_half_us),
   .stored_total   (rsp_chan.stored_total),
   .store_full     (rsp_chan.store_full)
);
`default_nettype wire
